/* sv/clcd_pkg.sv */
`timescale 1ns / 1ps

package clcd_pkg;

    // Request kinds as coded on req_type (code 7 is unused)
    typedef enum logic [2:0] {
        REQ_CMD    = 3'd0,
        REQ_TEXT   = 3'd1,
        REQ_CURSOR = 3'd2,
        REQ_CLEAR  = 3'd3,
        REQ_HOME   = 3'd4,
        REQ_INIT   = 3'd5,
        REQ_DEINIT = 3'd6
    } req_kind_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SETTLE   = 2'd0,
        CFG_CLEAR    = 2'd1,
        CFG_POWER_UP = 2'd2
    } cfg_idx_t;

    // Work handed from the front to the back
    typedef enum logic [1:0] {
        JOB_BYTE   = 2'd0,
        JOB_INIT   = 2'd1,
        JOB_DEINIT = 2'd2
    } job_kind_t;

    localparam int SETTLE_W   = 10;
    localparam int CLEAR_W    = 14;
    localparam int POWER_W    = 17;
    localparam int AFTER_W    = 14;
    localparam int STEP_W     = 4;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET   = 10'd100;
    localparam logic [CLEAR_W-1:0]  CLEAR_RESET    = 14'd2000;
    localparam logic [POWER_W-1:0]  POWER_UP_RESET = 17'd40000;

    localparam logic [AFTER_W-1:0] INIT_EXTRA_FIRST  = 14'd5000;
    localparam logic [AFTER_W-1:0] INIT_EXTRA_SECOND = 14'd100;
    localparam logic [AFTER_W-1:0] AFTER_MAX         = 14'h3FFF;

    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_FIRST   = 8'h20;
    localparam logic [7:0] CHAR_LAST    = 8'h7F;
    localparam logic [7:0] ROW1_BASE    = 8'h80;
    localparam logic [7:0] ROW2_BASE    = 8'hC0;

    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME      = 8'h02;
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0E;
    localparam logic [7:0] CMD_ENTRY_INC = 8'h06;

    localparam logic [3:0] NIB_WAKE  = 4'h3;
    localparam logic [3:0] NIB_4BIT  = 4'h2;

    // Last step of each job kind, and the init step that ends the clear command
    localparam logic [STEP_W-1:0] BYTE_LAST_STEP   = 4'd1;
    localparam logic [STEP_W-1:0] INIT_LAST_STEP   = 4'd11;
    localparam logic [STEP_W-1:0] DEINIT_LAST_STEP = 4'd3;
    localparam logic [STEP_W-1:0] INIT_CLEAR_STEP  = 4'd9;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] byte_value;
        logic [1:0] row;
        logic [5:0] column;
        logic       text_start;
    } req_t;

    typedef struct packed {
        logic               reg_select;
        logic [3:0]         nibble;
        logic [POWER_W-1:0] wait_before_us;
        logic [AFTER_W-1:0] wait_after_us;
        logic               last;
    } strobe_t;

    typedef struct packed {
        job_kind_t  kind;
        logic       rs;
        logic [7:0] value;
        logic       long_wait;
    } job_t;

    typedef struct packed {
        logic [SETTLE_W-1:0] settle_us;
        logic [CLEAR_W-1:0]  clear_wait_us;
        logic [POWER_W-1:0]  power_up_wait_us;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* sv/char_lcd_4bit_sequencer.sv */
`timescale 1ns / 1ps

// Character LCD sequencer for a 4-bit HD44780-style bus. Push one request
// per beat; each beat popped from the result side is one enable strobe with
// its register-select level, nibble and the waits around it. A byte takes
// two strobes (high nibble first), clear, home and set cursor likewise,
// deinit four and init twelve; requests that give nothing (filtered text,
// bad row, unused kind) leave no strobe. The strobe generator turns out one
// strobe per clock while the result buffer has room, so a request holds it
// until its strobes are all out; a request giving nothing never reaches it.
// Requests are accepted every cycle while the two-entry job queue between
// the classifier and the generator has room, and strobes keep flowing while
// the two-entry result buffer is not full. Configuration writes are always
// ready and must be made only while the block is idle.
module char_lcd_4bit_sequencer import clcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  req_t         req,
    output logic         empty,
    input  logic         pop,
    output strobe_t      strobe,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [POWER_W-1:0] cfg_data
);

    cfg_t      cfg_reg;
    logic      accept;
    logic      job_push;
    job_t      new_job;
    job_t      head_job;
    logic      job_pop;
    q_status_t jq_status;

    // Take configuration beats at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_us        <= SETTLE_RESET;
            cfg_reg.clear_wait_us    <= CLEAR_RESET;
            cfg_reg.power_up_wait_us <= POWER_UP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SETTLE:   cfg_reg.settle_us        <= cfg_data[SETTLE_W-1:0];
                CFG_CLEAR:    cfg_reg.clear_wait_us    <= cfg_data[CLEAR_W-1:0];
                CFG_POWER_UP: cfg_reg.power_up_wait_us <= cfg_data;
                default:      cfg_reg <= cfg_reg;   // drop writes beyond the map
            endcase
        end
    end

    // Hold off requests only when the job queue is full
    assign full   = jq_status.full;
    assign accept = push & ~full;

    clcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req      (req),
        .job_push (job_push),
        .job      (new_job)
    );

    clcd_job_q u_job_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (job_push),
        .wr_job (new_job),
        .pop    (job_pop),
        .head   (head_job),
        .status (jq_status)
    );

    clcd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .job     (head_job),
        .jq      (jq_status),
        .job_pop (job_pop),
        .pop     (pop),
        .empty   (empty),
        .strobe  (strobe)
    );

endmodule

/* sv/clcd_front.sv */
`timescale 1ns / 1ps

module clcd_front import clcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  req_t req,
    output logic job_push,
    output job_t job
);

    logic stopped_reg;
    logic stopped_next;
    logic stop_eff;
    logic produce;
    logic [7:0] addr;

    assign stop_eff = req.text_start ? 1'b0 : stopped_reg;
    assign addr     = {2'b00, req.column} - 8'd1;

    always_comb
    begin
        produce        = 1'b0;
        job.kind       = JOB_BYTE;
        job.rs         = 1'b0;
        job.value      = req.byte_value;
        job.long_wait  = 1'b0;
        stopped_next   = stopped_reg;
        case (req.req_type)
            REQ_CMD:
            begin
                produce = 1'b1;
            end
            REQ_TEXT:
            begin
                stopped_next = stop_eff;
                job.rs       = 1'b1;
                if (!stop_eff)
                begin
                    if (req.byte_value == CHAR_NEWLINE)
                        stopped_next = 1'b1;
                    else if (req.byte_value >= CHAR_FIRST && req.byte_value <= CHAR_LAST)
                        produce = 1'b1;
                end
            end
            REQ_CURSOR:
            begin
                if (req.row == 2'd1)
                begin
                    produce   = 1'b1;
                    job.value = ROW1_BASE | addr;
                end
                else if (req.row == 2'd2)
                begin
                    produce   = 1'b1;
                    job.value = ROW2_BASE | addr;
                end
            end
            REQ_CLEAR:
            begin
                produce       = 1'b1;
                job.value     = CMD_CLEAR;
                job.long_wait = 1'b1;
            end
            REQ_HOME:
            begin
                produce       = 1'b1;
                job.value     = CMD_HOME;
                job.long_wait = 1'b1;
            end
            REQ_INIT:
            begin
                produce  = 1'b1;
                job.kind = JOB_INIT;
            end
            REQ_DEINIT:
            begin
                produce  = 1'b1;
                job.kind = JOB_DEINIT;
            end
            default:
            begin
                produce = 1'b0;
            end
        endcase
    end

    assign job_push = accept & produce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stopped_reg <= 1'b0;
        else if (accept)
            stopped_reg <= stopped_next;
    end

endmodule

/* sv/clcd_job_q.sv */
`timescale 1ns / 1ps

module clcd_job_q import clcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      wr_job,
    input  logic      pop,
    output job_t      head,
    output q_status_t status
);

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push & ~status.full;
    assign do_pop       = pop & ~status.empty;
    assign head         = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wr_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("job queue count out of range");
`endif

endmodule

/* sv/clcd_back.sv */
`timescale 1ns / 1ps

module clcd_back import clcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  job_t      job,
    input  q_status_t jq,
    output logic      job_pop,
    input  logic      pop,
    output logic      empty,
    output strobe_t   strobe
);

    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               fire;
    logic               last_step;
    logic [7:0]         cur_byte;
    logic [3:0]         nib;
    logic [AFTER_W-1:0] extra;
    logic [POWER_W-1:0] pre_wait;
    logic [AFTER_W:0]   sum;
    strobe_t            gen;

    strobe_t    ob_mem [2];
    logic       ob_wr_ptr_reg;
    logic       ob_rd_ptr_reg;
    logic [1:0] ob_count_reg;
    logic [1:0] ob_count_next;
    logic       ob_space;
    logic       ob_pop;

    // Byte sent by the init sequence at a given step (steps four onwards)
    function automatic logic [7:0] init_byte(input logic [STEP_W-1:0] s);
        logic [7:0] b;
        begin
            case (s[2:1])
                2'd2:    b = CMD_FUNC_SET;
                2'd3:    b = CMD_DISP_ON;
                2'd0:    b = CMD_CLEAR;
                default: b = CMD_ENTRY_INC;
            endcase
            return b;
        end
    endfunction

    assign ob_space = (ob_count_reg != 2'd2);
    assign fire     = ~jq.empty & ob_space;

    always_comb
    begin
        last_step = 1'b0;
        cur_byte  = job.value;
        nib       = 4'h0;
        extra     = '0;
        pre_wait  = '0;
        case (job.kind)
            JOB_BYTE:
            begin
                last_step = (step_reg == BYTE_LAST_STEP);
                cur_byte  = job.value;
                nib       = step_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
                if (step_reg[0] && job.long_wait)
                    extra = cfg.clear_wait_us;
            end
            JOB_INIT:
            begin
                last_step = (step_reg == INIT_LAST_STEP);
                cur_byte  = init_byte(step_reg);
                if (step_reg < 4'd3)
                    nib = NIB_WAKE;
                else if (step_reg == 4'd3)
                    nib = NIB_4BIT;
                else
                    nib = step_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
                if (step_reg == 4'd0)
                begin
                    extra    = INIT_EXTRA_FIRST;
                    pre_wait = cfg.power_up_wait_us;
                end
                else if (step_reg == 4'd1)
                    extra = INIT_EXTRA_SECOND;
                else if (step_reg == INIT_CLEAR_STEP)
                    extra = cfg.clear_wait_us;
            end
            JOB_DEINIT:
            begin
                last_step = (step_reg == DEINIT_LAST_STEP);
                cur_byte  = step_reg[1] ? CMD_HOME : CMD_CLEAR;
                nib       = step_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
                if (step_reg[0])
                    extra = cfg.clear_wait_us;
            end
            default:
            begin
                last_step = 1'b1;
            end
        endcase
    end

    // Saturate settle plus extra at the field's top
    assign sum = {{(AFTER_W + 1 - SETTLE_W){1'b0}}, cfg.settle_us} + {1'b0, extra};

    always_comb
    begin
        gen.reg_select     = job.rs & (job.kind == JOB_BYTE);
        gen.nibble         = nib;
        gen.wait_before_us = pre_wait;
        gen.wait_after_us  = sum[AFTER_W] ? AFTER_MAX : sum[AFTER_W-1:0];
        gen.last           = last_step;
    end

    assign job_pop   = fire & last_step;
    assign step_next = fire ? (last_step ? '0 : step_reg + 4'd1) : step_reg;

    // Output buffer: two entries keep one strobe per cycle under steady pop
    assign ob_pop = pop & (ob_count_reg != 2'd0);
    assign empty  = (ob_count_reg == 2'd0);
    assign strobe = ob_mem[ob_rd_ptr_reg];

    always_comb
    begin
        ob_count_next = ob_count_reg;
        if (fire && !ob_pop)
            ob_count_next = ob_count_reg + 2'd1;
        else if (ob_pop && !fire)
            ob_count_next = ob_count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            ob_mem[ob_wr_ptr_reg] <= gen;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            ob_wr_ptr_reg <= 1'b0;
            ob_rd_ptr_reg <= 1'b0;
            ob_count_reg  <= 2'd0;
        end
        else
        begin
            step_reg <= step_next;
            if (fire)
                ob_wr_ptr_reg <= ~ob_wr_ptr_reg;
            if (ob_pop)
                ob_rd_ptr_reg <= ~ob_rd_ptr_reg;
            ob_count_reg <= ob_count_next;
        end
    end

`ifndef SYNTH
    a_mid_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != 4'd0) |-> !jq.empty)
        else $error("sequence in progress without a job");

    a_head_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != 4'd0) |-> $stable(job))
        else $error("job changed during its sequence");

    a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_step) |=> (step_reg == 4'd0))
        else $error("step not rewound after final strobe");

    a_ob_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ob_count_reg != 2'd3)
        else $error("output buffer count out of range");
`endif

endmodule
